// ===== rtl/assert_macros.svh =====
// Assertion macros used by williams_percent_r.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define WPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/wpr_pkg.sv =====
// Constants shared by the Williams %R block.
package wpr_pkg;

    localparam int CFG_W  = 7;
    localparam int PCT_W  = 15;
    localparam int QBITS  = 14;
    localparam int QBW    = 4;

    localparam logic [CFG_W-1:0]        WIN_RESET   = 7'd14;
    localparam logic [QBITS-1:0]        FULL_SCALE  = 14'd10000;
    localparam logic signed [PCT_W-1:0] FLAT_VALUE  = -15'sd5000;
    localparam logic signed [PCT_W-1:0] MIN_VALUE   = -15'sd10000;
    localparam logic signed [PCT_W-1:0] ZERO_VALUE  = 15'sd0;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

endpackage

// ===== rtl/wpr_cell.sv =====
// One window cell: stored bar range plus a running highest/lowest stage.
module wpr_cell
    import wpr_pkg::*;
#(
    parameter int PRICE_BITS = 32,
    parameter int CW         = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic [PRICE_BITS-1:0] i_hi,
    input  logic [PRICE_BITS-1:0] i_lo,
    input  logic                  i_vld,
    output logic [PRICE_BITS-1:0] o_hi,
    output logic [PRICE_BITS-1:0] o_lo,
    output logic                  o_vld,
    input  logic [CW-1:0]         i_eff,
    input  logic [PRICE_BITS-1:0] i_acc_hi,
    input  logic [PRICE_BITS-1:0] i_acc_lo,
    input  logic                  i_acc_fnd,
    output logic [PRICE_BITS-1:0] o_acc_hi,
    output logic [PRICE_BITS-1:0] o_acc_lo,
    output logic                  o_acc_fnd
);

    logic [PRICE_BITS-1:0] r_hi, r_lo, r_acc_hi, r_acc_lo;
    logic                  r_vld, r_acc_fnd;
    logic [PRICE_BITS-1:0] n_acc_hi, n_acc_lo;
    logic                  take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hi <= i_hi;
            r_lo <= i_lo;
        end
    end

    // cell takes part only when it lies inside the current window
    always_comb begin
        take     = r_vld && (i_eff > CW'(INDEX));
        n_acc_hi = (take && (!i_acc_fnd || r_hi > i_acc_hi)) ? r_hi : i_acc_hi;
        n_acc_lo = (take && (!i_acc_fnd || r_lo < i_acc_lo)) ? r_lo : i_acc_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_fnd <= 1'b0;
        end else begin
            r_acc_fnd <= i_acc_fnd | take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_hi <= n_acc_hi;
        r_acc_lo <= n_acc_lo;
    end

    assign o_hi      = r_hi;
    assign o_lo      = r_lo;
    assign o_vld     = r_vld;
    assign o_acc_hi  = r_acc_hi;
    assign o_acc_lo  = r_acc_lo;
    assign o_acc_fnd = r_acc_fnd;

endmodule

// ===== rtl/williams_percent_r.sv =====
// Williams %R oscillator: top level with window cell chain and serial divider.
// Each accepted bar shifts into a chain of WINDOW_MAX cells. A running
// highest-high / lowest-low moves one cell per cycle, so the scan always spans
// the whole chain, whatever the window length. The PREP and CHK states
// then prepare the operands. When a divide is needed, a restoring divider
// produces 14 quotient bits, one per cycle. The result then lands in the
// output register. The divide is skipped for an invalid result, a flat range,
// a zero or negative ratio, and a ratio of one or more. A result waits in
// S_DONE while the output register is full and the receiver holds off. A new
// bar is accepted only in S_IDLE, after the last result has been loaded. Bars
// with a clear range_valid are stored but skipped by the scan. The user must
// see that window_length is written only while idle; the block itself does not
// enforce it.
`include "assert_macros.svh"

module williams_percent_r
    import wpr_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [PRICE_BITS-1:0]   i_high_price,
    input  logic [PRICE_BITS-1:0]   i_low_price,
    input  logic [PRICE_BITS-1:0]   i_close_price,
    input  logic                    i_range_valid,
    input  logic                    i_close_valid,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [PCT_W-1:0] o_percent_r,
    output logic                    o_result_valid
);

    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int CNTW = $clog2(WINDOW_MAX);
    localparam int PW   = PRICE_BITS;
    localparam int NW   = PRICE_BITS + QBITS;

    logic [CFG_W-1:0] r_win;
    logic [CW-1:0]    eff;
    logic [2:0]       r_state;
    logic [CW-1:0]    r_seen, n_seen;
    logic [CNTW-1:0]  r_cnt;
    logic [QBW-1:0]   r_bit;
    logic             accept;

    logic [PW-1:0]    r_cl;
    logic             r_ok;
    logic [PW-1:0]    r_num, r_den;
    logic             r_sgn_ok, r_flat;
    logic             go_div;
    logic             load_out;
    logic [NW-1:0]    r_rem, r_dsh;
    logic [QBITS-1:0] r_q, n_q;
    logic             ge;

    logic signed [PCT_W-1:0] r_res, r_out_pct;
    logic                    r_res_v, r_out_rv, r_out_valid;

    logic [PW-1:0] c_hi  [WINDOW_MAX];
    logic [PW-1:0] c_lo  [WINDOW_MAX];
    logic          c_vld [WINDOW_MAX];
    logic [PW-1:0] a_hi  [WINDOW_MAX];
    logic [PW-1:0] a_lo  [WINDOW_MAX];
    logic          a_fnd [WINDOW_MAX];

    logic [PW-1:0] hi_s, lo_s;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_win == '0) begin
            eff = CW'(1);
        end else if (int'(r_win) > WINDOW_MAX) begin
            eff = CW'(WINDOW_MAX);
        end else begin
            eff = CW'(r_win);
        end
        n_seen = (r_seen < CW'(WINDOW_MAX)) ? r_seen + CW'(1) : r_seen;
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
            if (g == 0) begin : g_head
                wpr_cell #(.PRICE_BITS(PW), .CW(CW), .INDEX(g)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_shift   (accept),
                    .i_hi      (i_high_price),
                    .i_lo      (i_low_price),
                    .i_vld     (i_range_valid),
                    .o_hi      (c_hi[g]),
                    .o_lo      (c_lo[g]),
                    .o_vld     (c_vld[g]),
                    .i_eff     (eff),
                    .i_acc_hi  ('0),
                    .i_acc_lo  ('0),
                    .i_acc_fnd (1'b0),
                    .o_acc_hi  (a_hi[g]),
                    .o_acc_lo  (a_lo[g]),
                    .o_acc_fnd (a_fnd[g])
                );
            end else begin : g_body
                wpr_cell #(.PRICE_BITS(PW), .CW(CW), .INDEX(g)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_shift   (accept),
                    .i_hi      (c_hi[g-1]),
                    .i_lo      (c_lo[g-1]),
                    .i_vld     (c_vld[g-1]),
                    .o_hi      (c_hi[g]),
                    .o_lo      (c_lo[g]),
                    .o_vld     (c_vld[g]),
                    .i_eff     (eff),
                    .i_acc_hi  (a_hi[g-1]),
                    .i_acc_lo  (a_lo[g-1]),
                    .i_acc_fnd (a_fnd[g-1]),
                    .o_acc_hi  (a_hi[g]),
                    .o_acc_lo  (a_lo[g]),
                    .o_acc_fnd (a_fnd[g])
                );
            end
        end
    endgenerate

    assign hi_s = a_hi[WINDOW_MAX-1];
    assign lo_s = a_lo[WINDOW_MAX-1];

    assign ge  = (r_rem >= r_dsh);
    assign n_q = {r_q[QBITS-2:0], ge};

    // only a proper fraction below one needs the divider
    assign go_div   = r_res_v && !r_flat && (r_num != '0) && r_sgn_ok && (r_num < r_den);
    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_seen  <= n_seen;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == CNTW'(WINDOW_MAX - 1)) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (go_div) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt <= '0;
                r_cl  <= i_close_price;
                r_ok  <= (n_seen >= eff) && i_close_valid;
            end
            S_SCAN: begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            S_PREP: begin
                r_flat   <= (hi_s == lo_s);
                r_num    <= (r_cl > hi_s) ? r_cl - hi_s : hi_s - r_cl;
                r_den    <= (lo_s > hi_s) ? lo_s - hi_s : hi_s - lo_s;
                r_sgn_ok <= ((r_cl > hi_s) == (lo_s > hi_s));
                r_res_v  <= r_ok && a_fnd[WINDOW_MAX-1];
            end
            S_CHK: begin
                r_rem <= NW'(r_num) * NW'(FULL_SCALE);
                r_dsh <= NW'(r_den) << (QBITS - 1);
                r_q   <= '0;
                r_bit <= QBW'(QBITS - 1);
                if (!r_res_v) begin
                    r_res <= ZERO_VALUE;
                end else if (r_flat) begin
                    r_res <= FLAT_VALUE;
                end else if (r_num == '0 || !r_sgn_ok) begin
                    r_res <= ZERO_VALUE;
                end else if (r_num >= r_den) begin
                    r_res <= MIN_VALUE;
                end
            end
            S_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= n_q;
                r_bit <= r_bit - QBW'(1);
                if (r_bit == '0) begin
                    r_res <= -$signed({1'b0, n_q});
                end
            end
            S_DONE: begin
                if (load_out) begin
                    r_out_pct <= r_res;
                    r_out_rv  <= r_res_v;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_percent_r    = r_out_pct;
    assign o_result_valid = r_out_rv;

    `WPR_ASSERT_NXT(a_scan_start, i_valid && o_ready, r_state == S_SCAN)
    `WPR_ASSERT_IMP(a_pct_range, o_valid && o_result_valid, o_percent_r <= 0 && o_percent_r >= MIN_VALUE)
    `WPR_ASSERT_IMP(a_nan_zero, o_valid && !o_result_valid, o_percent_r == ZERO_VALUE)
    `WPR_ASSERT_IMP(a_seen_max, 1'b1, r_seen <= CW'(WINDOW_MAX))

endmodule

// ===== test/williams_percent_r_tb.sv =====
// Testbench for williams_percent_r: scoreboard-checked random and directed price bars.
module williams_percent_r_tb;
    import wpr_pkg::*;

    localparam int WIN_MAX   = 64;
    localparam int PX_W      = 32;
    localparam int PTR_W     = $clog2(WIN_MAX);
    localparam int RUN_LIMIT = 4000000;

    typedef struct packed {
        logic [PX_W-1:0] hi_px;
        logic [PX_W-1:0] lo_px;
        logic [PX_W-1:0] close_px;
        logic            range_ok;
        logic            close_ok;
    } t_bar;

    class t_percent_r_tracker;
        logic [PX_W-1:0]  high_ring [WIN_MAX];
        logic [PX_W-1:0]  low_ring [WIN_MAX];
        bit               valid_ring [WIN_MAX];
        bit [PTR_W-1:0]   wr_ptr;
        int unsigned      bar_count;
        logic [CFG_W-1:0] window_reg;
        logic [PCT_W-1:0] pct_q [$];
        logic             ok_q [$];
        int               errors;

        function new();
            foreach (valid_ring[i]) valid_ring[i] = 1'b0;
            wr_ptr     = '0;
            bar_count  = 0;
            window_reg = WIN_RESET;
            errors     = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] v);
            window_reg = v;
        endfunction

        function int pending();
            return pct_q.size();
        endfunction

        function int unsigned span();
            if (window_reg == 0) return 1;
            if (window_reg > WIN_MAX) return WIN_MAX;
            return int'(window_reg);
        endfunction

        function logic [PCT_W-1:0] ratio(longint unsigned hi, longint unsigned lo,
                                         longint unsigned cl);
            longint unsigned num, den, q;
            bit num_neg, den_neg;
            logic signed [PCT_W-1:0] mag;
            if (hi == lo) return FLAT_VALUE;
            num_neg = cl > hi;
            num     = num_neg ? cl - hi : hi - cl;
            den_neg = lo > hi;
            den     = den_neg ? lo - hi : hi - lo;
            if (num == 0 || num_neg != den_neg) return ZERO_VALUE;
            q = num * longint'(FULL_SCALE) / den;
            if (q > longint'(FULL_SCALE)) q = longint'(FULL_SCALE);
            mag = q[PCT_W-1:0];
            return -mag;
        endfunction

        function void note_bar(t_bar b);
            bit [PTR_W-1:0] slot, k;
            int unsigned win;
            longint unsigned top, bot;
            bit found;
            logic [PCT_W-1:0] pct;
            logic ok;
            win   = span();
            slot  = wr_ptr;
            high_ring[slot]  = b.hi_px;
            low_ring[slot]   = b.lo_px;
            valid_ring[slot] = b.range_ok;
            wr_ptr = wr_ptr + 1'b1;
            if (bar_count < WIN_MAX) bar_count++;
            found = 1'b0;
            top   = 0;
            bot   = 0;
            pct   = '0;
            ok    = 1'b0;
            if (bar_count >= win && b.close_ok) begin
                for (int unsigned i = 0; i < win; i++) begin
                    k = slot - PTR_W'(i);
                    if (valid_ring[k]) begin
                        if (!found || high_ring[k] > top) top = high_ring[k];
                        if (!found || low_ring[k] < bot) bot = low_ring[k];
                        found = 1'b1;
                    end
                end
                if (found) begin
                    pct = ratio(top, bot, b.close_px);
                    ok  = 1'b1;
                end
            end
            pct_q.insert(pct_q.size(), pct);
            ok_q.insert(ok_q.size(), ok);
        endfunction

        function void check_result(logic [PCT_W-1:0] pct, logic ok);
            logic [PCT_W-1:0] exp_pct;
            logic exp_ok;
            if (pct_q.size() == 0) begin
                $error("unexpected transfer: percent_r %0d result_valid %0b", $signed(pct), ok);
                errors++;
                return;
            end
            exp_pct = pct_q.pop_front();
            exp_ok  = ok_q.pop_front();
            if (ok !== exp_ok) begin
                $error("result_valid: expected %0b, got %0b", exp_ok, ok);
                errors++;
            end
            if (pct !== exp_pct) begin
                $error("percent_r: expected %0d, got %0d", $signed(exp_pct), $signed(pct));
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]        i_cfg_data     = '0;
    logic                    i_valid        = 1'b0;
    logic                    o_ready;
    logic [PX_W-1:0]         i_high_price   = '0;
    logic [PX_W-1:0]         i_low_price    = '0;
    logic [PX_W-1:0]         i_close_price  = '0;
    logic                    i_range_valid  = 1'b0;
    logic                    i_close_valid  = 1'b0;
    logic                    o_valid;
    logic                    i_ready        = 1'b0;
    logic signed [PCT_W-1:0] o_percent_r;
    logic                    o_result_valid;

    t_percent_r_tracker tracker = new();
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_left     = 0;
    longint mid_px        = 64'd100000;

    williams_percent_r #(
        .WINDOW_MAX (WIN_MAX),
        .PRICE_BITS (PX_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_high_price   (i_high_price),
        .i_low_price    (i_low_price),
        .i_close_price  (i_close_price),
        .i_range_valid  (i_range_valid),
        .i_close_valid  (i_close_valid),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_percent_r    (o_percent_r),
        .o_result_valid (o_result_valid)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_bar bar_of(logic [PX_W-1:0] hi, logic [PX_W-1:0] lo,
                                    logic [PX_W-1:0] cl, logic rv, logic cv);
        t_bar b;
        b.hi_px    = hi;
        b.lo_px    = lo;
        b.close_px = cl;
        b.range_ok = rv;
        b.close_ok = cv;
        return b;
    endfunction

    // Mostly a random walk of ordered bars; some closes outside the range, some pure noise.
    function automatic t_bar make_bar();
        t_bar b;
        int kind;
        longint spread, top, bot;
        kind = $urandom_range(99);
        if ($urandom_range(49) == 0) mid_px = longint'($urandom);
        mid_px = mid_px + longint'($urandom_range(2000)) - 1000;
        if (mid_px < 0) mid_px = 0;
        if (mid_px > 64'hFFFF_FFFF) mid_px = 64'hFFFF_FFFF;
        spread = longint'($urandom >> $urandom_range(31));
        top = mid_px + spread;
        bot = mid_px - spread;
        if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
        if (bot < 0) bot = 0;
        b.hi_px    = top[PX_W-1:0];
        b.lo_px    = bot[PX_W-1:0];
        b.close_px = $urandom_range(top[31:0], bot[31:0]);
        if (kind >= 80 && kind < 90) begin
            b.close_px = $urandom;
        end else if (kind >= 90) begin
            b.hi_px    = $urandom;
            b.lo_px    = $urandom;
            b.close_px = $urandom;
        end
        b.range_ok = ($urandom_range(99) >= 8);
        b.close_ok = ($urandom_range(99) >= 5);
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_bar(t_bar b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_high_price  <= b.hi_px;
        i_low_price   <= b.lo_px;
        i_close_price <= b.close_px;
        i_range_valid <= b.range_ok;
        i_close_valid <= b.close_ok;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_bar(b);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_window(logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_window(v);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                tracker.check_result(o_percent_r, o_result_valid);
        end
    end

    initial begin
        #RUN_LIMIT;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] win_plan [9];
        win_plan = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd23, 7'd2, 7'd63,
                     CFG_W'($urandom_range(64, 1)), 7'd14};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window: warm-up, then the first defined result
        send_bar(bar_of(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_bar(bar_of(32'h0, 32'h0, 32'h0, 1'b1, 1'b1));
        send_bar(bar_of(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 1'b1, 1'b1));
        send_bar(bar_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 1'b0, 1'b0));
        for (int i = 0; i < 10; i++)
            send_bar(bar_of(32'(1000 + i * 10), 32'(900 - i), 32'd950, 1'b1, 1'b1));
        drain_results();

        write_window(7'd1);
        send_bar(bar_of(32'd500, 32'd500, 32'd500, 1'b1, 1'b1));          // flat range
        send_bar(bar_of(32'd500, 32'd400, 32'd600, 1'b1, 1'b1));          // close above high
        send_bar(bar_of(32'd500, 32'd400, 32'd500, 1'b1, 1'b1));          // close at high
        send_bar(bar_of(32'd500, 32'd400, 32'd100, 1'b1, 1'b1));          // below low, clamps
        send_bar(bar_of(32'd400, 32'd500, 32'd450, 1'b1, 1'b1));          // inverted range
        send_bar(bar_of(32'd400, 32'd500, 32'd300, 1'b1, 1'b1));          // inverted, clamps to 0
        send_bar(bar_of(32'd500, 32'd400, 32'd450, 1'b1, 1'b0));          // no close
        send_bar(bar_of(32'd500, 32'd400, 32'd450, 1'b0, 1'b1));          // no valid entry
        send_bar(bar_of(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1));
        send_bar(bar_of(32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1, 1'b1));
        send_bar(bar_of(32'h1, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1));

        for (int ph = 0; ph < 9; ph++) begin
            drain_results();
            write_window(win_plan[ph]);
            send_idle_pct = (ph < 3) ? 7 : (ph < 6) ? 49 : 0;
            recv_idle_pct = (ph < 3) ? 49 : (ph < 6) ? 7 : 0;
            if (ph == 3) hold_left = 1500;    // output backs up, input must stall
            repeat (155) send_bar(make_bar());
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
